// File: hdl/pps_pkg.sv
// ---------------------------------------------------------------------------
// pps_pkg: shared types and constants for the priority scheduler
// Field widths, cell command and candidate token layouts, controller states.
// ---------------------------------------------------------------------------
package pps_pkg;

    localparam int SLOT_W = 6;   // slot index, covers up to 64 cells
    localparam int CNT_W  = 7;   // loaded/completed counts, up to 64
    localparam int PID_W  = 5;
    localparam int ARR_W  = 16;
    localparam int BUR_W  = 16;
    localparam int PRI_W  = 8;
    localparam int TIME_W = 24;
    localparam int SUM_W  = 28;
    localparam int IN_W   = 40;
    localparam int OUT_W  = 144;

    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
    localparam logic [SUM_W-1:0]  SUM_MAX  = {SUM_W{1'b1}};

    // command kinds carried on s_tuser
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // best-so-far token passed along the cell row
    typedef struct packed {
        logic              valid;
        logic              found;
        logic [SLOT_W-1:0] idx;
        logic [PRI_W-1:0]  prio;
        logic [ARR_W-1:0]  arrival;
        logic [BUR_W-1:0]  burst;
        logic [BUR_W-1:0]  remaining;
    } cand_t;

    // broadcast from the controller to every cell
    typedef struct packed {
        logic              wr_en;
        logic              dec_en;
        logic [SLOT_W-1:0] slot;
        logic [ARR_W-1:0]  arrival;
        logic [BUR_W-1:0]  burst;
        logic [PRI_W-1:0]  prio;
        logic [CNT_W-1:0]  count;
        logic [TIME_W-1:0] now;
    } cell_cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_CALC,
        ST_WAIT,
        ST_OUT
    } state_t;

    // result word, first field in the low bits
    function automatic logic [OUT_W-1:0] pack_out(
        input logic              ran,
        input logic [PID_W-1:0]  pid,
        input logic              sw,
        input logic              fin,
        input logic [TIME_W-1:0] ct,
        input logic [TIME_W-1:0] tat,
        input logic [TIME_W-1:0] wt,
        input logic [SUM_W-1:0]  tw,
        input logic [SUM_W-1:0]  tt,
        input logic              done,
        input logic              lerr
    );
        return {6'b0, lerr, done, tt, tw, wt, tat, ct, fin, sw, pid, ran};
    endfunction

endpackage

// File: hdl/pps_cell.sv
// ---------------------------------------------------------------------------
// pps_cell: one process table slot
// Holds one entry, merges it into the passing candidate token and registers
// the token for the next cell.
// ---------------------------------------------------------------------------
module pps_cell #(
    parameter int IDX = 0
) (
    input  logic              clk,
    input  logic              rst_n,
    input  pps_pkg::cell_cmd_t cmd,
    input  pps_pkg::cand_t    cand_in,
    output pps_pkg::cand_t    cand_out
);
    import pps_pkg::*;

    localparam logic [SLOT_W-1:0] MY_SLOT = SLOT_W'(IDX);
    localparam logic [CNT_W-1:0]  MY_CNT  = CNT_W'(IDX);

    logic [ARR_W-1:0] arrival_reg;
    logic [BUR_W-1:0] burst_reg;
    logic [PRI_W-1:0] prio_reg;
    logic [BUR_W-1:0] remaining_reg;
    logic             valid_reg;
    cand_t            cand_reg;
    cand_t            cand_next;
    logic             eligible;
    logic             better;
    logic             hit;

    assign hit = (cmd.slot == MY_SLOT);

    // entry storage: load and one-tick decrement
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en && hit)
        begin
            arrival_reg   <= cmd.arrival;
            burst_reg     <= cmd.burst;
            prio_reg      <= cmd.prio;
            remaining_reg <= cmd.burst;
        end
        else if (cmd.dec_en && hit)
        begin
            remaining_reg <= remaining_reg - BUR_W'(1);
        end
    end

    // compare own entry with the incoming best
    always_comb
    begin
        eligible = (MY_CNT < cmd.count) &&
                   ({{(TIME_W-ARR_W){1'b0}}, arrival_reg} <= cmd.now) &&
                   (remaining_reg != '0);
        better   = !cand_in.found || (prio_reg < cand_in.prio) ||
                   ((prio_reg == cand_in.prio) && (arrival_reg < cand_in.arrival));
        cand_next = cand_in;
        if (eligible && better)
        begin
            cand_next.found     = 1'b1;
            cand_next.idx       = MY_SLOT;
            cand_next.prio      = prio_reg;
            cand_next.arrival   = arrival_reg;
            cand_next.burst     = burst_reg;
            cand_next.remaining = remaining_reg;
        end
    end

    // token stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= cand_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        cand_reg <= cand_next;
    end

    always_comb
    begin
        cand_out       = cand_reg;
        cand_out.valid = valid_reg;
    end

endmodule

// File: hdl/pps_ctrl.sv
// ---------------------------------------------------------------------------
// pps_ctrl: scheduler controller
// Stream handshakes, counters, time, totals and result word assembly.
// ---------------------------------------------------------------------------
module pps_ctrl #(
    parameter int MAX_PROCS = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [pps_pkg::IN_W-1:0]  s_tdata,
    input  logic                      s_tuser,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [pps_pkg::OUT_W-1:0] m_tdata,
    output pps_pkg::cell_cmd_t        cmd,
    output pps_pkg::cand_t            launch,
    input  pps_pkg::cand_t            result
);
    import pps_pkg::*;

    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_PROCS);

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  loaded_reg, loaded_next;
    logic [CNT_W-1:0]  completed_reg, completed_next;
    logic [TIME_W-1:0] time_reg, time_next;
    logic [PID_W-1:0]  last_run_reg, last_run_next;
    logic [SUM_W-1:0]  sum_w_reg, sum_w_next;
    logic [SUM_W-1:0]  sum_t_reg, sum_t_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [OUT_W-1:0]  m_tdata_reg, m_tdata_next;
    cand_t             win_reg, win_next;
    logic              fin_reg, fin_next;
    logic [TIME_W-1:0] ct_reg, ct_next;
    logic [TIME_W-1:0] tat_reg, tat_next;
    logic [TIME_W-1:0] wt_reg, wt_next;

    logic [ARR_W-1:0]  in_arrival;
    logic [BUR_W-1:0]  in_burst;
    logic [PRI_W-1:0]  in_prio;
    logic              out_free;
    logic              accept;
    logic [TIME_W-1:0] time_inc;
    logic [PID_W-1:0]  win_pid;
    logic [SUM_W:0]    sum_w_add;
    logic [SUM_W:0]    sum_t_add;

    assign in_arrival = s_tdata[15:0];
    assign in_burst   = s_tdata[31:16];
    assign in_prio    = s_tdata[39:32];
    assign out_free   = !m_tvalid_reg || m_tready;
    assign s_tready   = (state_reg == ST_IDLE) && out_free;
    assign accept     = s_tvalid && s_tready;
    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign time_inc   = (time_reg == TIME_MAX) ? TIME_MAX : time_reg + TIME_W'(1);
    assign win_pid    = PID_W'({1'b0, win_reg.idx} + (SLOT_W+1)'(1));
    assign sum_w_add  = {1'b0, sum_w_reg} + (SUM_W+1)'(wt_reg);
    assign sum_t_add  = {1'b0, sum_t_reg} + (SUM_W+1)'(tat_reg);

    // next state and outputs
    always_comb
    begin
        state_next     = state_reg;
        loaded_next    = loaded_reg;
        completed_next = completed_reg;
        time_next      = time_reg;
        last_run_next  = last_run_reg;
        sum_w_next     = sum_w_reg;
        sum_t_next     = sum_t_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        m_tdata_next   = m_tdata_reg;
        win_next       = win_reg;
        fin_next       = fin_reg;
        ct_next        = ct_reg;
        tat_next       = tat_reg;
        wt_next        = wt_reg;

        cmd            = '0;
        cmd.slot       = loaded_reg[SLOT_W-1:0];
        cmd.arrival    = in_arrival;
        cmd.burst      = (in_burst == '0) ? BUR_W'(1) : in_burst;
        cmd.prio       = in_prio;
        cmd.count      = loaded_reg;
        cmd.now        = time_reg;
        launch         = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (s_tuser == CMD_LOAD)
                    begin
                        m_tvalid_next = 1'b1;
                        if (loaded_reg < MAX_CNT)
                        begin
                            cmd.wr_en    = 1'b1;
                            loaded_next  = loaded_reg + CNT_W'(1);
                            m_tdata_next = pack_out(1'b0, PID_W'(loaded_next), 1'b0, 1'b0,
                                                    '0, '0, '0, sum_w_reg, sum_t_reg,
                                                    completed_reg == loaded_next, 1'b0);
                        end
                        else
                        begin
                            m_tdata_next = pack_out(1'b0, '0, 1'b0, 1'b0,
                                                    '0, '0, '0, sum_w_reg, sum_t_reg,
                                                    completed_reg == loaded_reg, 1'b1);
                        end
                    end
                    else
                    begin
                        launch.valid = 1'b1;
                        state_next   = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (result.valid)
                begin
                    win_next   = result;
                    state_next = ST_CALC;
                end
            end
            ST_CALC:
            begin
                time_next  = time_inc;
                ct_next    = time_inc;
                tat_next   = time_inc - TIME_W'(win_reg.arrival);
                fin_next   = win_reg.found && (win_reg.remaining == BUR_W'(1));
                cmd.dec_en = win_reg.found;
                cmd.slot   = win_reg.idx;
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                wt_next    = (tat_reg >= TIME_W'(win_reg.burst)) ?
                             tat_reg - TIME_W'(win_reg.burst) : '0;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    if (fin_reg)
                    begin
                        completed_next = completed_reg + CNT_W'(1);
                        sum_w_next = sum_w_add[SUM_W] ? SUM_MAX : sum_w_add[SUM_W-1:0];
                        sum_t_next = sum_t_add[SUM_W] ? SUM_MAX : sum_t_add[SUM_W-1:0];
                    end
                    if (win_reg.found)
                    begin
                        last_run_next = win_pid;
                    end
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = pack_out(win_reg.found,
                                             win_reg.found ? win_pid : '0,
                                             win_reg.found && (last_run_reg != win_pid),
                                             fin_reg,
                                             fin_reg ? ct_reg : '0,
                                             fin_reg ? tat_reg : '0,
                                             fin_reg ? wt_reg : '0,
                                             sum_w_next, sum_t_next,
                                             completed_next == loaded_reg, 1'b0);
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            loaded_reg    <= '0;
            completed_reg <= '0;
            time_reg      <= '0;
            last_run_reg  <= '0;
            sum_w_reg     <= '0;
            sum_t_reg     <= '0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            loaded_reg    <= loaded_next;
            completed_reg <= completed_next;
            time_reg      <= time_next;
            last_run_reg  <= last_run_next;
            sum_w_reg     <= sum_w_next;
            sum_t_reg     <= sum_t_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        m_tdata_reg <= m_tdata_next;
        win_reg     <= win_next;
        fin_reg     <= fin_next;
        ct_reg      <= ct_next;
        tat_reg     <= tat_next;
        wt_reg      <= wt_next;
    end

`ifndef SYNTHESIS
    // token leaves the row only while a scan is pending
    a_token_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> state_reg == ST_SCAN)
        else $error("candidate token outside scan");

    // never more completions than loads
    a_count_order: assert property (@(posedge clk) disable iff (!rst_n)
        completed_reg <= loaded_reg)
        else $error("completed count exceeds loaded count");

    // decrement only for a found winner, in the calc step
    a_dec_guard: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.dec_en |-> (state_reg == ST_CALC) && win_reg.found)
        else $error("decrement without winner");

    // an accepted tick starts a scan
    a_tick_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && (s_tuser == CMD_TICK)) |=> state_reg == ST_SCAN)
        else $error("tick did not start scan");
`endif

endmodule

// File: hdl/preemptive_priority_scheduler.sv
// ---------------------------------------------------------------------------
// preemptive_priority_scheduler: preemptive priority process scheduler
// A row of MAX_PROCS table cells plus a controller; one result per command.
// ---------------------------------------------------------------------------
// A load word (s_tuser = 0) appends a process and returns its one-based id in
// the next cycle; a full table returns load_error. A tick word (s_tuser = 1)
// sends a candidate token down the row of cells, one cell per cycle, each cell
// keeping the better of its own ready entry and the token (lowest priority
// value, then earlier arrival, then lower slot). After the pass through the
// cell row, the winner goes through the time/turnaround, waiting time and
// totals/result steps; the last step waits until the output is free. One
// command is in flight at a time; the next word is taken only once the
// previous result has left or leaves in the same cycle. Table entries hold no
// reset value; only loaded slots take part in a scan.
module preemptive_priority_scheduler #(
    parameter int MAX_PROCS = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // arrival[15:0], burst[31:16], priority_req[39:32]
    input  logic [pps_pkg::IN_W-1:0]  s_tdata,
    // command: 0 load, 1 tick
    input  logic                      s_tuser,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // ran[0], proc_id[5:1], switched[6], finished[7], completion_time[31:8],
    // turnaround[55:32], waiting[79:56], total_waiting[107:80],
    // total_turnaround[135:108], all_done[136], load_error[137], zero pad
    output logic [pps_pkg::OUT_W-1:0] m_tdata
);
    import pps_pkg::*;

    cell_cmd_t cmd;
    cand_t     chain [MAX_PROCS+1];

    pps_ctrl #(
        .MAX_PROCS (MAX_PROCS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cmd      (cmd),
        .launch   (chain[0]),
        .result   (chain[MAX_PROCS])
    );

    // row of table cells
    for (genvar i = 0; i < MAX_PROCS; i++)
    begin : g_cell
        pps_cell #(
            .IDX (i)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .cmd      (cmd),
            .cand_in  (chain[i]),
            .cand_out (chain[i+1])
        );
    end

endmodule
